FILE: rtl/segalloc_pkg.sv
`default_nettype none
package segalloc_pkg;

  localparam int REQ_W     = 21;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int ORDER_W   = 5;
  localparam int POLICY_W  = 2;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_REQUEST   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LIST_FREE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST_USED = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd4;

  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd1;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_BUDDY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_ORDER = 2'd1;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_POST, S_HALVE, S_PLAN,
    S_SHUP_RD, S_SHUP_WR, S_FILL, S_REQ_DONE, S_RL_RDL, S_RL_RDH, S_RL_EV,
    S_RL_WR, S_SHDN_RD, S_SHDN_WR, S_RL_DONE, S_EMIT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_SCAN_RD, OP_SCAN_EV, OP_PREP, OP_HALVE,
    OP_PLAN, OP_SHUP_RD, OP_SHUP_WR, OP_FILL, OP_REQ_DONE, OP_RL_RDL,
    OP_RL_RDH, OP_RL_EV, OP_RL_WR, OP_SHDN_RD, OP_SHDN_WR, OP_RL_DONE,
    OP_EMIT_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic              in_kind_ok;
    logic [KIND_W-1:0] kind;
    logic              scan_end;
    logic              ev_emit;
    logic              out_free;
    logic              fnd;
    logic              cand;
    logic              req_err;
    logic              buddy;
    logic              halve_more;
    logic              full;
    logic              shup_more;
    logic              fill_last;
    logic              merged;
    logic              shdn_more;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/segalloc_ctrl.sv
`default_nettype none
module segalloc_ctrl
  import segalloc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire dp_stat_t stat,
  output logic          in_stall,
  output dp_cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_stall   = (state != S_IDLE);
    case (state)
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = stat.in_kind_ok ? S_SCAN_RD : S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          state_next = S_POST;
        end else begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (!stat.ev_emit || stat.out_free) begin
          cmd.op     = OP_SCAN_EV;
          state_next = S_SCAN_RD;
        end
      end
      S_POST: begin
        cmd.op = OP_PREP;
        case (stat.kind)
          KIND_REQUEST: begin
            if (stat.req_err || !stat.cand) begin
              state_next = S_EMIT;
            end else if (stat.buddy) begin
              state_next = S_HALVE;
            end else begin
              state_next = S_PLAN;
            end
          end
          KIND_RELEASE: state_next = stat.fnd ? S_RL_RDL : S_EMIT;
          default:      state_next = S_EMIT;
        endcase
      end
      S_HALVE: begin
        if (stat.halve_more) begin
          cmd.op = OP_HALVE;
        end else begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        if (stat.full) begin
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_PLAN;
          state_next = S_SHUP_RD;
        end
      end
      S_SHUP_RD: begin
        if (stat.shup_more) begin
          cmd.op     = OP_SHUP_RD;
          state_next = S_SHUP_WR;
        end else begin
          state_next = S_FILL;
        end
      end
      S_SHUP_WR: begin
        cmd.op     = OP_SHUP_WR;
        state_next = S_SHUP_RD;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (stat.fill_last) begin
          state_next = S_REQ_DONE;
        end
      end
      S_REQ_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_REQ_DONE;
          state_next = S_IDLE;
        end
      end
      S_RL_RDL: begin
        cmd.op     = OP_RL_RDL;
        state_next = S_RL_RDH;
      end
      S_RL_RDH: begin
        cmd.op     = OP_RL_RDH;
        state_next = S_RL_EV;
      end
      S_RL_EV: begin
        cmd.op     = OP_RL_EV;
        state_next = stat.merged ? S_RL_RDL : S_RL_WR;
      end
      S_RL_WR: begin
        cmd.op     = OP_RL_WR;
        state_next = S_SHDN_RD;
      end
      S_SHDN_RD: begin
        if (stat.shdn_more) begin
          cmd.op     = OP_SHDN_RD;
          state_next = S_SHDN_WR;
        end else begin
          state_next = S_RL_DONE;
        end
      end
      S_SHDN_WR: begin
        cmd.op     = OP_SHDN_WR;
        state_next = S_SHDN_RD;
      end
      S_RL_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_RL_DONE;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT_END;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/segalloc_dp.sv
`default_nettype none
module segalloc_dp
  import segalloc_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 20,
  parameter int OWNER_BITS   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [OWNER_BITS-1:0] owner,
  input  wire logic [REQ_W-1:0]      req_size,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [OWNER_BITS-1:0]      seg_owner_out,
  output logic [ADDR_BITS-1:0]       seg_start_out,
  output logic [ADDR_BITS:0]         seg_length_out,
  output logic                       last
);

  localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int LW   = ADDR_BITS + 1;
  localparam int CMPW = (LW > REQ_W) ? LW : REQ_W;
  localparam int NW   = $clog2(LW + 1);
  localparam int FW   = ((CW > NW) ? CW : NW) + 1;
  localparam logic [ORDER_W-1:0] ORDER_MAX =
    (ADDR_BITS > 31) ? ORDER_W'(31) : ORDER_W'(ADDR_BITS);
  localparam logic [ORDER_W-1:0] ORDER_RST =
    (ADDR_BITS < 20) ? ORDER_W'(ADDR_BITS) : ORDER_W'(20);

  // segment table
  logic [ADDR_BITS-1:0]  m_start [MAX_SEGMENTS];
  logic [LW-1:0]         m_len   [MAX_SEGMENTS];
  logic [OWNER_BITS-1:0] m_owner [MAX_SEGMENTS];
  logic                  m_used  [MAX_SEGMENTS];

  logic [ADDR_BITS-1:0]  rd_start;
  logic [LW-1:0]         rd_len;
  logic [OWNER_BITS-1:0] rd_owner;
  logic                  rd_used;

  logic                  wr_en, rd_en;
  logic [IW-1:0]         wr_addr, rd_addr;
  logic [ADDR_BITS-1:0]  wr_start;
  logic [LW-1:0]         wr_len;
  logic [OWNER_BITS-1:0] wr_owner;
  logic                  wr_used;

  logic [POLICY_W-1:0]   policy;
  logic [ORDER_W-1:0]    order, new_order;
  logic [CW-1:0]         count;
  logic [ADDR_BITS-1:0]  next_pos;

  logic [KIND_W-1:0]     kind_r;
  logic [OWNER_BITS-1:0] own_r;
  logic [REQ_W-1:0]      req_r;
  logic [CW-1:0]         idx;

  logic                  fnd;
  logic [IW-1:0]         fnd_idx;
  logic [ADDR_BITS-1:0]  fnd_start;
  logic [LW-1:0]         fnd_len;
  logic                  cand, cand_hi;
  logic [IW-1:0]         cand_idx;
  logic [ADDR_BITS-1:0]  cand_start;
  logic [LW-1:0]         cand_len;
  logic                  pend_v;
  logic [OWNER_BITS-1:0] pend_owner;
  logic [ADDR_BITS-1:0]  pend_start;
  logic [LW-1:0]         pend_len;

  logic [LW-1:0]         hl, len_alloc;
  logic [NW-1:0]         n;
  logic [CW-1:0]         d, ptr, kk, lo, hi;
  logic [ADDR_BITS-1:0]  cur_start, nb_start;
  logic [LW-1:0]         cur_len, nb_len;
  logic                  nb_used;

  logic                  init_wr;
  logic                  fits, hi_start, take, owner_hit, is_list, match;
  logic                  buddy, lo_ok, hi_ok, pfree, nfree;
  logic                  b_ok, b_low, down, up;
  logic [LW-1:0]         bud, cs_ext;
  logic [NW-1:0]         sh;
  logic [LW-1:0]         fill_blk;

  logic                  emit;
  logic [STATUS_W-1:0]   e_status;
  logic [OWNER_BITS-1:0] e_owner;
  logic [ADDR_BITS-1:0]  e_start;
  logic [LW-1:0]         e_len;
  logic                  e_last;

  assign new_order = (cfg_wr && cfg_index == REG_MEM_ORDER) ?
                     ((cfg_data > ORDER_MAX) ? ORDER_MAX : cfg_data) : order;
  assign init_wr   = (cmd.op == OP_INIT) || (cfg_wr && cfg_index == REG_MEM_ORDER);

  assign buddy     = (policy == POL_BUDDY);
  assign fits      = !rd_used && (CMPW'(rd_len) >= CMPW'(req_r));
  assign hi_start  = (rd_start >= next_pos);
  assign owner_hit = rd_used && (rd_owner == own_r);
  assign is_list   = (kind_r == KIND_LIST_FREE) || (kind_r == KIND_LIST_USED);
  assign match     = (kind_r == KIND_LIST_USED) ? rd_used : !rd_used;

  always_comb begin
    case (policy)
      POL_BEST: take = fits && (!cand || rd_len < cand_len);
      POL_NEXT: take = fits && (!cand || (hi_start && !cand_hi));
      default:  take = fits && !cand;
    endcase
  end

  // release merge
  assign lo_ok  = (lo != '0);
  assign hi_ok  = ((hi + CW'(1)) < count);
  assign pfree  = lo_ok && !nb_used;
  assign nfree  = hi_ok && !rd_used;
  assign cs_ext = LW'(cur_start);
  assign bud    = cs_ext ^ cur_len;
  assign b_ok   = (cur_len != '0) && ((cur_len & (cur_len - LW'(1))) == '0) &&
                  ((cs_ext & (cur_len - LW'(1))) == '0);
  assign b_low  = ((cs_ext & cur_len) != '0);
  assign down   = b_ok && b_low && pfree && (LW'(nb_start) == bud) && (nb_len == cur_len);
  assign up     = b_ok && !b_low && nfree && (LW'(rd_start) == bud) && (rd_len == cur_len);

  // split pieces
  assign sh       = n - NW'(kk) + NW'(1);
  assign fill_blk = cand_len >> sh;

  always_comb begin
    stat.in_kind_ok = (kind <= KIND_LIST_USED);
    stat.kind       = kind_r;
    stat.scan_end   = (idx == count);
    stat.ev_emit    = is_list && match && pend_v;
    stat.out_free   = !out_valid || !out_stall;
    stat.fnd        = fnd;
    stat.cand       = cand;
    stat.req_err    = (req_r == '0) || fnd;
    stat.buddy      = buddy;
    stat.halve_more = (CMPW'(hl >> 1) >= CMPW'(req_r));
    stat.full       = buddy ? ((FW'(count) + FW'(n)) > FW'(MAX_SEGMENTS)) :
                      ((CMPW'(cand_len) != CMPW'(req_r)) && (count == CW'(MAX_SEGMENTS)));
    stat.shup_more  = (ptr > CW'(cand_idx));
    stat.fill_last  = (kk == d);
    stat.merged     = buddy && (down || up);
    stat.shdn_more  = (ptr < count);
  end

  // memory port control
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_start = rd_start;
    wr_len   = rd_len;
    wr_owner = rd_owner;
    wr_used  = rd_used;
    rd_en    = 1'b0;
    rd_addr  = '0;
    if (init_wr) begin
      wr_en    = 1'b1;
      wr_start = '0;
      wr_len   = LW'(1) << new_order;
      wr_owner = '0;
      wr_used  = 1'b0;
    end else begin
      case (cmd.op)
        OP_SCAN_RD: begin
          rd_en   = 1'b1;
          rd_addr = idx[IW-1:0];
        end
        OP_SHUP_RD, OP_SHDN_RD: begin
          rd_en   = 1'b1;
          rd_addr = ptr[IW-1:0];
        end
        OP_SHUP_WR: begin
          wr_en   = 1'b1;
          wr_addr = IW'(ptr + d);
        end
        OP_SHDN_WR: begin
          wr_en   = 1'b1;
          wr_addr = IW'(ptr - d);
        end
        OP_FILL: begin
          wr_en   = 1'b1;
          wr_addr = IW'(CW'(cand_idx) + kk);
          if (kk == '0) begin
            wr_start = cand_start;
            wr_len   = len_alloc;
            wr_owner = own_r;
            wr_used  = 1'b1;
          end else begin
            wr_owner = '0;
            wr_used  = 1'b0;
            if (buddy) begin
              wr_start = cand_start + fill_blk[ADDR_BITS-1:0];
              wr_len   = fill_blk;
            end else begin
              wr_start = cand_start + ADDR_BITS'(req_r);
              wr_len   = LW'(CMPW'(cand_len) - CMPW'(req_r));
            end
          end
        end
        OP_RL_RDL: begin
          rd_en   = 1'b1;
          rd_addr = IW'(lo - CW'(1));
        end
        OP_RL_RDH: begin
          rd_en   = 1'b1;
          rd_addr = IW'(hi + CW'(1));
        end
        OP_RL_WR: begin
          wr_en    = 1'b1;
          wr_addr  = lo[IW-1:0];
          wr_start = cur_start;
          wr_len   = cur_len;
          wr_owner = '0;
          wr_used  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      m_start[wr_addr] <= wr_start;
      m_len[wr_addr]   <= wr_len;
      m_owner[wr_addr] <= wr_owner;
      m_used[wr_addr]  <= wr_used;
    end
    if (rd_en) begin
      rd_start <= m_start[rd_addr];
      rd_len   <= m_len[rd_addr];
      rd_owner <= m_owner[rd_addr];
      rd_used  <= m_used[rd_addr];
    end
  end

  // result beat
  always_comb begin
    emit     = 1'b0;
    e_status = STAT_OK;
    e_owner  = own_r;
    e_start  = '0;
    e_len    = '0;
    e_last   = 1'b1;
    case (cmd.op)
      OP_SCAN_EV: begin
        if (stat.ev_emit) begin
          emit    = 1'b1;
          e_owner = pend_owner;
          e_start = pend_start;
          e_len   = pend_len;
          e_last  = 1'b0;
        end
      end
      OP_REQ_DONE: begin
        emit    = 1'b1;
        e_start = cand_start;
        e_len   = len_alloc;
      end
      OP_RL_DONE: begin
        emit    = 1'b1;
        e_start = fnd_start;
        e_len   = fnd_len;
      end
      OP_EMIT_END: begin
        emit = 1'b1;
        case (kind_r)
          KIND_REQUEST: begin
            e_status = (stat.req_err || !cand) ? STAT_NO_FIT : STAT_TABLE_FULL;
          end
          KIND_RELEASE, KIND_FIND: begin
            if (fnd) begin
              e_start = fnd_start;
              e_len   = fnd_len;
            end else begin
              e_status = STAT_NOT_FOUND;
            end
          end
          default: begin
            if (pend_v) begin
              e_owner = pend_owner;
              e_start = pend_start;
              e_len   = pend_len;
            end else begin
              e_status = STAT_EMPTY;
              e_owner  = '0;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status         <= e_status;
      seg_owner_out  <= e_owner;
      seg_start_out  <= e_start;
      seg_length_out <= e_len;
      last           <= e_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= POL_BEST;
      order    <= ORDER_RST;
      count    <= CW'(1);
      next_pos <= '0;
      fnd      <= 1'b0;
      cand     <= 1'b0;
      cand_hi  <= 1'b0;
      pend_v   <= 1'b0;
      idx      <= '0;
    end else begin
      if (cfg_wr && cfg_index == REG_POLICY) begin
        policy <= cfg_data[POLICY_W-1:0];
      end
      if (init_wr) begin
        order    <= new_order;
        count    <= CW'(1);
        next_pos <= '0;
      end
      case (cmd.op)
        OP_LOAD: begin
          idx     <= '0;
          fnd     <= 1'b0;
          cand    <= 1'b0;
          cand_hi <= 1'b0;
          pend_v  <= 1'b0;
        end
        OP_SCAN_EV: begin
          idx <= idx + CW'(1);
          if (owner_hit && !fnd) begin
            fnd <= 1'b1;
          end
          if (take) begin
            cand    <= 1'b1;
            cand_hi <= hi_start;
          end
          if (is_list && match) begin
            pend_v <= 1'b1;
          end
        end
        OP_REQ_DONE: begin
          count <= count + d;
          if (policy == POL_NEXT) begin
            next_pos <= cand_start;
          end
        end
        OP_RL_DONE: count <= count - d;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r <= kind;
        own_r  <= owner;
        req_r  <= req_size;
      end
      OP_SCAN_EV: begin
        if (owner_hit && !fnd) begin
          fnd_idx   <= idx[IW-1:0];
          fnd_start <= rd_start;
          fnd_len   <= rd_len;
        end
        if (take) begin
          cand_idx   <= idx[IW-1:0];
          cand_start <= rd_start;
          cand_len   <= rd_len;
        end
        if (is_list && match) begin
          pend_owner <= rd_used ? rd_owner : '0;
          pend_start <= rd_start;
          pend_len   <= rd_len;
        end
      end
      OP_PREP: begin
        hl        <= cand_len;
        n         <= '0;
        lo        <= CW'(fnd_idx);
        hi        <= CW'(fnd_idx);
        cur_start <= fnd_start;
        cur_len   <= fnd_len;
      end
      OP_HALVE: begin
        hl <= hl >> 1;
        n  <= n + NW'(1);
      end
      OP_PLAN: begin
        d         <= buddy ? CW'(n) :
                     ((CMPW'(cand_len) != CMPW'(req_r)) ? CW'(1) : CW'(0));
        ptr       <= count - CW'(1);
        kk        <= '0;
        len_alloc <= buddy ? hl : LW'(req_r);
      end
      OP_SHUP_WR: ptr <= ptr - CW'(1);
      OP_FILL:    kk  <= kk + CW'(1);
      OP_RL_RDH: begin
        nb_start <= rd_start;
        nb_len   <= rd_len;
        nb_used  <= rd_used;
      end
      OP_RL_EV: begin
        if (buddy) begin
          if (down) begin
            lo        <= lo - CW'(1);
            cur_start <= nb_start;
            cur_len   <= cur_len << 1;
          end else if (up) begin
            hi      <= hi + CW'(1);
            cur_len <= cur_len << 1;
          end
        end else begin
          cur_len <= cur_len + (nfree ? rd_len : '0) + (pfree ? nb_len : '0);
          if (pfree) begin
            lo        <= lo - CW'(1);
            cur_start <= nb_start;
          end
          if (nfree) begin
            hi <= hi + CW'(1);
          end
        end
      end
      OP_RL_WR: begin
        d   <= hi - lo;
        ptr <= hi + CW'(1);
      end
      OP_SHDN_WR: ptr <= ptr + CW'(1);
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || !out_stall))
    else $error("result beat overwritten");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SCAN_RD) |-> (idx < count))
    else $error("scan index past table");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SHUP_WR) |-> ((FW'(ptr) + FW'(d)) < FW'(MAX_SEGMENTS)))
    else $error("shift beyond table");

endmodule
`default_nettype wire

FILE: rtl/segment_allocator_fit_policies.sv
// Segment allocator with best, first, next and buddy fit placement.
// Input channel (in_valid/in_stall) takes one command beat: request, release,
// find, list free or list assigned. Output channel (out_valid/out_stall) gives
// one result beat per command, or one beat per listed segment with last set on
// the final one. Unknown kinds give no beat.
// The table lives in a memory with one read and one write port, and every
// command scans it entry by entry, a read state then an evaluate state per
// entry. A request then shifts the entries after the chosen entry i up to open
// room, writes one entry per new piece, and in buddy mode first halves the block.
// A release adds merge steps (read below, read above, evaluate), then moves entries down.
// One command is worked on at a time; in_stall is low only when idle.
// The result register holds a beat while out_stall is high; the block waits
// for it to be taken before loading the next one.
// Reset (rst, synchronous) sets policy best fit, order 20 (ADDR_BITS if smaller),
// then writes the single free segment. Writing mem_order does the same at once.
`default_nettype none
module segment_allocator_fit_policies
  import segalloc_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 20,
  parameter int OWNER_BITS   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [OWNER_BITS-1:0] owner,
  input  wire logic [REQ_W-1:0]      req_size,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [OWNER_BITS-1:0]      seg_owner_out,
  output logic [ADDR_BITS-1:0]       seg_start_out,
  output logic [ADDR_BITS:0]         seg_length_out,
  output logic                       last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  segalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  segalloc_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS),
    .OWNER_BITS   (OWNER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr         (cfg_wr),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .owner          (owner),
    .req_size       (req_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .seg_owner_out  (seg_owner_out),
    .seg_start_out  (seg_start_out),
    .seg_length_out (seg_length_out),
    .last           (last)
  );

endmodule
`default_nettype wire
